[rtl/htbd_pkg.sv]
package htbd_pkg;

    localparam int CHAR_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int NIB_W          = 4;
    localparam int CAP_W          = 16;
    localparam int SO_FAR_W       = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [CAP_W-1:0] CAPACITY_RST = 16'hFFFF;

    // character codes
    localparam logic [CHAR_W-1:0] CH_DIGIT_LO = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_DIGIT_HI = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_UPPER_LO = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UPPER_HI = 16'h0046;
    localparam logic [CHAR_W-1:0] CH_LOWER_LO = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LOWER_HI = 16'h0066;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_TAB      = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_LF       = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_CR       = 16'h000D;

    typedef logic [1:0] t_cls;
    localparam t_cls CLS_DIGIT = 2'd0;
    localparam t_cls CLS_SEP   = 2'd1;
    localparam t_cls CLS_BAD   = 2'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              final_char;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]   byte_out;
        logic                byte_valid;
        logic [SO_FAR_W-1:0] bytes_so_far;
        logic                bad_char;
        logic                end_of_text;
    } t_out_item;

endpackage

[rtl/htbd_in_if.sv]
interface htbd_in_if;
    logic                valid;
    logic                ready;
    htbd_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/htbd_out_if.sv]
interface htbd_out_if;
    logic                valid;
    logic                ready;
    htbd_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/htbd_classify.sv]
module htbd_classify (
    input  logic [htbd_pkg::CHAR_W-1:0] i_char,
    output htbd_pkg::t_cls              o_cls,
    output logic [htbd_pkg::NIB_W-1:0]  o_nib
);

    logic [htbd_pkg::CHAR_W-1:0] w_off_digit;
    logic [htbd_pkg::CHAR_W-1:0] w_off_upper;
    logic [htbd_pkg::CHAR_W-1:0] w_off_lower;

    assign w_off_digit = i_char - htbd_pkg::CH_DIGIT_LO;
    assign w_off_upper = i_char - htbd_pkg::CH_UPPER_LO;
    assign w_off_lower = i_char - htbd_pkg::CH_LOWER_LO;

    always_comb begin
        o_cls = htbd_pkg::CLS_BAD;
        o_nib = '0;
        if (i_char >= htbd_pkg::CH_DIGIT_LO && i_char <= htbd_pkg::CH_DIGIT_HI) begin
            o_cls = htbd_pkg::CLS_DIGIT;
            o_nib = w_off_digit[htbd_pkg::NIB_W-1:0];
        end else if (i_char >= htbd_pkg::CH_UPPER_LO && i_char <= htbd_pkg::CH_UPPER_HI) begin
            o_cls = htbd_pkg::CLS_DIGIT;
            o_nib = w_off_upper[htbd_pkg::NIB_W-1:0] + 4'd10;
        end else if (i_char >= htbd_pkg::CH_LOWER_LO && i_char <= htbd_pkg::CH_LOWER_HI) begin
            o_cls = htbd_pkg::CLS_DIGIT;
            o_nib = w_off_lower[htbd_pkg::NIB_W-1:0] + 4'd10;
        end else if (i_char == htbd_pkg::CH_SPACE || i_char == htbd_pkg::CH_TAB ||
                     i_char == htbd_pkg::CH_LF || i_char == htbd_pkg::CH_CR) begin
            o_cls = htbd_pkg::CLS_SEP;
        end
    end

endmodule

[rtl/htbd_step.sv]
module htbd_step #(
    parameter int COUNT_BITS = htbd_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  htbd_pkg::t_in_item           i_item,
    input  logic [htbd_pkg::CAP_W-1:0]   i_capacity,
    output htbd_pkg::t_out_item          o_result
);

    localparam int LW = (COUNT_BITS > htbd_pkg::CAP_W) ? COUNT_BITS : htbd_pkg::CAP_W;

    logic [htbd_pkg::BYTE_W-1:0] r_partial, n_partial;
    logic                        r_pending, n_pending;
    logic                        r_after, n_after;
    logic [COUNT_BITS-1:0]       r_count, n_count;
    logic                        r_halted, n_halted;

    htbd_pkg::t_cls              w_cls;
    logic [htbd_pkg::NIB_W-1:0]  w_nib;
    logic                        w_below;
    logic                        w_valid;
    logic [htbd_pkg::BYTE_W-1:0] w_byte;
    logic [htbd_pkg::BYTE_W-1:0] w_shifted;
    logic [COUNT_BITS-1:0]       w_count;
    logic [LW-1:0]               w_count_ext;

    htbd_classify u_classify (
        .i_char (i_item.char_code),
        .o_cls  (w_cls),
        .o_nib  (w_nib)
    );

    // limit is min(capacity, all-ones count)
    assign w_below = (LW'(r_count) < LW'(i_capacity)) && (r_count != '1);
    assign w_shifted = {r_partial[htbd_pkg::NIB_W-1:0], w_nib};

    always_comb begin
        n_partial = r_partial;
        n_pending = r_pending;
        n_after   = r_after;
        n_halted  = r_halted;
        w_valid   = 1'b0;
        w_byte    = '0;
        if (!r_halted && w_below) begin
            case (w_cls)
                htbd_pkg::CLS_DIGIT: begin
                    if (r_pending) begin
                        w_valid   = 1'b1;
                        w_byte    = w_shifted;
                        n_partial = '0;
                        n_pending = 1'b0;
                    end else begin
                        n_partial = w_shifted;
                        n_pending = 1'b1;
                    end
                    n_after = 1'b0;
                end
                htbd_pkg::CLS_SEP: begin
                    if (!r_after) begin
                        if (r_pending) begin
                            w_valid = 1'b1;
                            w_byte  = r_partial;
                        end
                        n_partial = '0;
                        n_pending = 1'b0;
                        n_after   = 1'b1;
                    end
                end
                default: begin
                    n_halted = 1'b1;
                end
            endcase
        end
        // lone digit flushed at end of string when no byte came above; the flushed byte adds to the count
        if (i_item.final_char && !w_valid && n_pending && !n_halted && w_below) begin
            w_valid = 1'b1;
            w_byte  = n_partial;
        end
        w_count = r_count + COUNT_BITS'(w_valid);
        n_count = w_count;
        if (i_item.final_char) begin
            n_partial = '0;
            n_pending = 1'b0;
            n_after   = 1'b1;
            n_count   = '0;
        end
    end

    assign w_count_ext = LW'(w_count);

    always_comb begin
        o_result.byte_out     = w_byte;
        o_result.byte_valid   = w_valid;
        o_result.bytes_so_far = w_count_ext[htbd_pkg::SO_FAR_W-1:0];
        o_result.bad_char     = n_halted;
        o_result.end_of_text  = i_item.final_char;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pending <= 1'b0;
            r_after   <= 1'b1;
            r_count   <= '0;
            r_halted  <= 1'b0;
        end else if (i_advance) begin
            r_partial <= n_partial;
            r_pending <= n_pending;
            r_after   <= n_after;
            r_count   <= n_count;
            r_halted  <= n_halted && !i_item.final_char;
        end
    end

endmodule

[rtl/hex_text_to_bytes_decoder_unit.sv]
// channel   dir  payload                                          handshake
// i_in      in   char_code[15:0], final_char                      valid/ready
// o_out     out  byte_out[7:0], byte_valid, bytes_so_far[15:0],   valid/ready
//                bad_char, end_of_text
// cfg       in   i_cfg_wdata[15:0] = capacity                     i_cfg_we
//
// one result per item, one item per cycle unless o_out stalls; an item
// passes the input register, then the decode step into the result register
// the string state updates in the same cycle the result register loads
// synchronous active-low reset clears all string state, capacity to 65535
// a stalled output holds the result and the input register, then i_in.ready drops
module hex_text_to_bytes_decoder_unit #(
    parameter int COUNT_BITS = htbd_pkg::COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    htbd_in_if.sink                    i_in,
    htbd_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [htbd_pkg::CAP_W-1:0] i_cfg_wdata
);

    logic [htbd_pkg::CAP_W-1:0] r_capacity;
    logic                       r_in_valid;
    htbd_pkg::t_in_item         r_in_item;
    logic                       r_out_valid;
    htbd_pkg::t_out_item        r_out_item;

    logic                       w_advance;
    htbd_pkg::t_out_item        w_result;

    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

    htbd_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_advance),
        .i_item     (r_in_item),
        .i_capacity (r_capacity),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= htbd_pkg::CAPACITY_RST;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

endmodule

[tb/sv/htbd_result_checker.sv]
module htbd_result_checker
    import htbd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    htbd_in_if               i_in,
    htbd_out_if              i_out,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
    localparam int MAX_REPORTS = 10;

    logic [CAP_W-1:0]      capacity;
    logic [BYTE_W-1:0]     nib_acc;
    logic                  half_byte_held;
    logic                  at_separator;
    logic [COUNT_BITS-1:0] byte_count;
    logic                  stopped;
    logic                  bad_seen;
    t_out_item             expected_bytes[$];
    int                    fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void clear_string();
        nib_acc        = '0;
        half_byte_held = 1'b0;
        at_separator   = 1'b1;
        byte_count     = '0;
        stopped        = 1'b0;
        bad_seen       = 1'b0;
    endfunction

    function automatic logic room_left();
        longint unsigned lim;
        lim = (longint'(capacity) < COUNT_MAX) ? longint'(capacity) : COUNT_MAX;
        return longint'(byte_count) < lim;
    endfunction

    // one character in, one result out; string state advances as the block's does
    function automatic t_out_item decode_char(input logic [CHAR_W-1:0] code, input logic fin);
        t_cls             kind;
        logic [NIB_W-1:0] nib;
        t_out_item        res;
        res = '0;
        nib = '0;
        if (code >= CH_DIGIT_LO && code <= CH_DIGIT_HI) begin
            kind = CLS_DIGIT;
            nib  = NIB_W'(code - CH_DIGIT_LO);
        end else if (code >= CH_UPPER_LO && code <= CH_UPPER_HI) begin
            kind = CLS_DIGIT;
            nib  = NIB_W'(code - CH_UPPER_LO + 16'd10);
        end else if (code >= CH_LOWER_LO && code <= CH_LOWER_HI) begin
            kind = CLS_DIGIT;
            nib  = NIB_W'(code - CH_LOWER_LO + 16'd10);
        end else if (code == CH_SPACE || code == CH_TAB || code == CH_LF || code == CH_CR) begin
            kind = CLS_SEP;
        end else begin
            kind = CLS_BAD;
        end

        if (!stopped && room_left()) begin
            case (kind)
                CLS_DIGIT: begin
                    nib_acc = {nib_acc[NIB_W-1:0], nib};
                    if (half_byte_held) begin
                        res.byte_out   = nib_acc;
                        res.byte_valid = 1'b1;
                        byte_count     = byte_count + 1'b1;
                        nib_acc        = '0;
                        half_byte_held = 1'b0;
                    end else begin
                        half_byte_held = 1'b1;
                    end
                    at_separator = 1'b0;
                end
                CLS_SEP: begin
                    // only the first of a run of separators does anything
                    if (!at_separator) begin
                        if (half_byte_held) begin
                            res.byte_out   = nib_acc;
                            res.byte_valid = 1'b1;
                            byte_count     = byte_count + 1'b1;
                        end
                        nib_acc        = '0;
                        half_byte_held = 1'b0;
                        at_separator   = 1'b1;
                    end
                end
                default: begin
                    bad_seen = 1'b1;
                    stopped  = 1'b1;
                end
            endcase
        end

        // lone digit left over at the end of a clean string
        if (fin && !res.byte_valid && half_byte_held && !bad_seen && room_left()) begin
            res.byte_out   = nib_acc;
            res.byte_valid = 1'b1;
            byte_count     = byte_count + 1'b1;
        end

        res.bytes_so_far = SO_FAR_W'(byte_count);
        res.bad_char     = bad_seen;
        res.end_of_text  = fin;
        if (fin) clear_string();
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item seen;
        if (!i_rst_n) begin
            capacity = CAPACITY_RST;
            clear_string();
            expected_bytes.delete();
        end else begin
            if (i_cfg_we) capacity = i_cfg_wdata;
            if (i_in.valid && i_in.ready) begin
                expected_bytes.push_back(decode_char(i_in.payload.char_code,
                                                     i_in.payload.final_char));
            end
            if (i_out.valid && i_out.ready) begin
                seen = i_out.payload;
                if (expected_bytes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display({"%0t: result with nothing owed: ",
                                  "byte=%h valid=%b count=%0d bad=%b end=%b"},
                                 $time, seen.byte_out, seen.byte_valid, seen.bytes_so_far,
                                 seen.bad_char, seen.end_of_text);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (seen.byte_out !== want.byte_out || seen.byte_valid !== want.byte_valid ||
                        seen.bytes_so_far !== want.bytes_so_far ||
                        seen.bad_char !== want.bad_char ||
                        seen.end_of_text !== want.end_of_text) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display({"%0t: mismatch, expected ",
                                      "byte=%h valid=%b count=%0d bad=%b end=%b"},
                                     $time, want.byte_out, want.byte_valid, want.bytes_so_far,
                                     want.bad_char, want.end_of_text);
                            $display({"%0t:           got      ",
                                      "byte=%h valid=%b count=%0d bad=%b end=%b"},
                                     $time, seen.byte_out, seen.byte_valid, seen.bytes_so_far,
                                     seen.bad_char, seen.end_of_text);
                        end
                    end
                end
            end
        end
        o_pending <= expected_bytes.size();
    end

endmodule

[tb/sv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import htbd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int N_PHASES    = 10;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    int               hold_reqs = 0;
    int               burst_left = 0;
    int               n_chars = 0;
    int               n_strings = 0;
    int               n_settings = 0;

    htbd_in_if  in_ch ();
    htbd_out_if out_ch ();

    hex_text_to_bytes_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    htbd_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d results still owed",
                     cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // result side: runs of ready, short stalls, the odd long one, plus requested hold-offs
    initial begin : result_sink
        int   run_left;
        int   pick;
        int   hold_done;
        logic level;
        run_left  = 0;
        hold_done = 0;
        level     = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_done != hold_reqs) begin
                hold_done++;
                level    = 1'b0;
                run_left = HOLD_CYCLES;
            end else if (run_left <= 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    level    = 1'b1;
                    run_left = $urandom_range(1, 40);
                end else if (pick < 92) begin
                    level    = 1'b0;
                    run_left = $urandom_range(1, 3);
                end else begin
                    level    = 1'b0;
                    run_left = $urandom_range(10, 60);
                end
            end
            out_ch.ready <= level;
            run_left--;
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] code, input logic fin);
        t_in_item item;
        int       pick;
        int       gap;
        item.char_code  = code;
        item.final_char = fin;
        in_ch.payload <= item;
        in_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        n_chars++;
        if (fin) n_strings++;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      gap = 0;
            else if (pick < 80) gap = $urandom_range(1, 3);
            else if (pick < 92) gap = $urandom_range(4, 12);
            else if (pick < 97) gap = $urandom_range(20, 50);
            else                burst_left = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic idle_input();
        in_ch.valid <= 1'b0;
    endtask

    // first edge makes the owed count include the item just accepted
    task automatic wait_idle();
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        cfg_wdata <= cap;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [CHAR_W-1:0] hex_char(input int nib, input logic upper);
        if (nib < 10) return CH_DIGIT_LO + CHAR_W'(nib);
        return (upper ? CH_UPPER_LO : CH_LOWER_LO) + CHAR_W'(nib - 10);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char(input logic noisy);
        int                r;
        logic [CHAR_W-1:0] c;
        r = $urandom_range(0, 99);
        if (noisy && r < 12) begin
            case ($urandom_range(0, 3))
                0: c = CHAR_W'($urandom);
                1: begin
                    // digit in the low byte, high byte set
                    c = hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1)));
                    c[15:8] = 8'($urandom_range(1, 255));
                end
                2: begin
                    case ($urandom_range(0, 7))
                        0: c = CH_DIGIT_LO - 1'b1;
                        1: c = CH_DIGIT_HI + 1'b1;
                        2: c = CH_UPPER_LO - 1'b1;
                        3: c = CH_UPPER_HI + 1'b1;
                        4: c = CH_LOWER_LO - 1'b1;
                        5: c = CH_LOWER_HI + 1'b1;
                        6: c = '0;
                        default: c = '1;
                    endcase
                end
                default: c = CHAR_W'($urandom_range(CH_SPACE + 1, CH_LOWER_HI + 24));
            endcase
        end else if (r < 78) begin
            c = hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1)));
        end else begin
            case ($urandom_range(0, 3))
                0: c = CH_SPACE;
                1: c = CH_TAB;
                2: c = CH_LF;
                default: c = CH_CR;
            endcase
        end
        return c;
    endfunction

    task automatic send_string(input int len, input logic noisy, input logic leave_open);
        for (int i = 0; i < len; i++) begin
            send_char(pick_char(noisy), (i == len - 1) && !leave_open);
        end
    endtask

    initial begin : stimulus
        int               target;
        int               sent;
        int               len;
        logic             noisy;
        logic             leave_open;
        logic [CAP_W-1:0] cap;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_capacity(CAPACITY_RST);

        // pairs of digits, both cases, range ends
        send_char(CH_DIGIT_LO, 1'b0);
        send_char(CH_DIGIT_HI, 1'b0);
        send_char(CH_UPPER_LO, 1'b0);
        send_char(CH_LOWER_HI, 1'b0);
        send_char(CH_LOWER_LO, 1'b0);
        send_char(CH_UPPER_HI, 1'b0);
        // separator right after a byte, then a repeated one
        send_char(CH_SPACE, 1'b0);
        send_char(CH_SPACE, 1'b0);
        // lone digit closed by a separator
        send_char(hex_char(7, 1'b0), 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_UPPER_HI, 1'b0);
        send_char(CH_UPPER_HI, 1'b0);
        // lone digit flushed by the last character
        send_char(hex_char(12, 1'b0), 1'b1);
        // bad character mid-string, rest ignored including the last one
        send_char(hex_char(1, 1'b0), 1'b0);
        send_char(CH_DIGIT_LO - 1'b1, 1'b0);
        send_char(hex_char(2, 1'b0), 1'b0);
        send_char('1, 1'b1);
        // one-character strings just past digit range edges, then a zero code and a lone digit
        send_char(CH_DIGIT_HI + 1'b1, 1'b1);
        send_char(CH_UPPER_LO - 1'b1, 1'b1);
        send_char(CH_UPPER_HI + 1'b1, 1'b1);
        send_char(CH_LOWER_LO - 1'b1, 1'b1);
        send_char(CH_LOWER_HI + 1'b1, 1'b1);
        send_char('0, 1'b1);
        send_char(hex_char(5, 1'b1), 1'b1);
        idle_input();
        wait_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: cap = 3;
                1: cap = '0;
                2: cap = CAPACITY_RST;
                3: cap = 1;
                4: cap = CAP_W'($urandom_range(0, 65535));
                5: cap = 2;
                default: cap = $urandom_range(0, 1) ? CAP_W'($urandom_range(4, 24)) : CAPACITY_RST;
            endcase
            // long output stall while this phase keeps offering items
            if (p == 2) hold_reqs++;
            set_capacity(cap);
            target = (cap == 0) ? 60 : 190;
            sent = 0;
            while (sent < target) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
                noisy = ($urandom_range(0, 4) == 0);
                // a string may stay open across the next capacity change
                leave_open = (sent + len >= target) && $urandom_range(0, 1);
                send_string(len, noisy, leave_open);
                sent += len;
            end
            idle_input();
            wait_idle();
        end

        repeat (6) @(posedge i_clk);
        $display("decoded %0d characters in %0d closed strings under %0d capacity settings",
                 n_chars, n_strings, n_settings);
        $display("capacities included 0, 1, 2, 3 and 65535; mismatches %0d, results owed %0d",
                 fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
